/* rtl/core/usf_pkg.sv */
// ----------------------------------------------------------------------------
// usf_pkg
// Shared types, constants and helpers for the universal sink finder.
// ----------------------------------------------------------------------------
`default_nettype none

package usf_pkg;

  localparam int ROW_W   = 16;  // Bits in one matrix row.
  localparam int SINK_W  = 4;   // Bits of the reported sink index.
  localparam int BIDX_W  = 8;   // Width of a person index given to usf_knows.

  typedef logic [ROW_W-1:0] usf_row_t;

  typedef struct packed {
    logic              found;
    logic [SINK_W-1:0] sink_index;
  } usf_result_t;

  // A row names only people 0 to ROW_W-1, so higher indexes are never known.
  function automatic logic usf_knows(input usf_row_t row, input logic [BIDX_W-1:0] idx);
    logic hit;
    hit = 1'b0;
    if (idx < BIDX_W'(ROW_W)) begin
      hit = row[idx[SINK_W-1:0]];
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/universal_sink_finder.sv */
// ----------------------------------------------------------------------------
// universal_sink_finder
// Finds the universal sink of a knows-matrix received one row per request.
// ----------------------------------------------------------------------------
// Rows of the matrix arrive one request per cycle and are written into a row
// memory; the request with last_row set closes the set, and the matrix size N
// is the number of rows stored (at most MAX_PEOPLE; extra rows are dropped,
// though a closing extra row still starts the search). The closing request
// starts a search that walks the row memory twice through its single read
// port, once to eliminate candidates and once to verify the survivor, and
// stalls the row channel while it runs. Exactly one result follows each
// closing row: found, and the sink index (zero when none is found). The
// result sits in an output register until taken; further rows of the next
// set are accepted meanwhile, but a closing row waits until the pending
// result has been taken.
`default_nettype none

module universal_sink_finder
  import usf_pkg::*;
#(
  parameter int MAX_PEOPLE = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              row_valid,
  output logic                   row_stall,
  input  wire logic [ROW_W-1:0]  row_bits,
  input  wire logic              last_row,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic                   found,
  output logic [SINK_W-1:0]      sink_index
);

  // Count width holds MAX_PEOPLE itself; the address width indexes the rows.
  localparam int CW = $clog2(MAX_PEOPLE + 1);
  localparam int AW = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;

  logic [CW-1:0] rows_loaded;
  logic          row_accept;
  logic          has_room;
  logic [CW-1:0] close_n;
  logic          walk_busy;
  logic          walk_done;
  usf_result_t   walk_res;
  logic [AW-1:0] rd_addr;
  usf_row_t      rd_data;

  // A closing row may only start a search when the result register is free,
  // and not in the cycle where the previous search is still handing over its
  // answer, so a finished search always has a place to put its answer.
  assign row_stall  = walk_busy || ((result_valid || walk_done) && last_row);
  assign row_accept = row_valid && !row_stall;
  assign has_room   = (rows_loaded < CW'(MAX_PEOPLE));
  assign close_n    = has_room ? (rows_loaded + CW'(1)) : rows_loaded;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
    end else if (row_accept) begin
      if (last_row) begin
        rows_loaded <= '0;
      end else if (has_room) begin
        rows_loaded <= rows_loaded + CW'(1);
      end
    end
  end

  usf_matrix_mem #(
    .DEPTH (MAX_PEOPLE),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (row_accept && has_room),
    .wr_addr (rows_loaded[AW-1:0]),
    .wr_data (row_bits),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The walker leaves IDLE at the same edge that writes the closing row, so
  // every read that it issues already sees that row.
  usf_walker #(
    .CW (CW),
    .AW (AW)
  ) u_walker (
    .clk     (clk),
    .rst     (rst),
    .start   (row_accept && last_row),
    .n       (close_n),
    .busy    (walk_busy),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (walk_done),
    .res     (walk_res)
  );

  // Output register holds the answer until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (walk_done) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_done) begin
      found      <= walk_res.found;
      sink_index <= walk_res.sink_index;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/usf_matrix_mem.sv */
// ----------------------------------------------------------------------------
// usf_matrix_mem
// Row store: one write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module usf_matrix_mem
  import usf_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire usf_row_t      wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output usf_row_t           rd_data
);

  usf_row_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/core/usf_walker.sv */
// ----------------------------------------------------------------------------
// usf_walker
// Candidate elimination pass, then a verify pass, over the stored rows.
// ----------------------------------------------------------------------------
`default_nettype none

module usf_walker
  import usf_pkg::*;
#(
  parameter int CW = 5,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [CW-1:0] n,
  output logic               busy,
  output logic [AW-1:0]      rd_addr,
  input  wire usf_row_t      rd_data,
  output logic               done,
  output usf_result_t        res
);

  typedef enum logic [1:0] {
    IDLE,
    ELIM,
    VERIFY
  } state_t;

  state_t          state;
  logic [CW-1:0]   n_r;
  logic [CW-1:0]   iss;
  logic            chk_valid;
  logic [CW-1:0]   chk_idx;
  logic [CW-1:0]   cand;
  usf_row_t        cand_row;
  logic            ok;

  logic            issue_go;
  logic            chk_last;
  logic            cand_knows_chk;
  logic            chk_knows_cand;
  logic            ok_next;
  logic [BIDX_W-1:0] cand_ext;

  assign busy     = (state != IDLE);
  assign issue_go = busy && (iss < n_r);
  assign rd_addr  = iss[AW-1:0];
  assign chk_last = chk_valid && (chk_idx == (n_r - CW'(1)));
  assign cand_ext = BIDX_W'(cand);

  assign cand_knows_chk = usf_knows(cand_row, BIDX_W'(chk_idx));
  assign chk_knows_cand = usf_knows(rd_data, cand_ext);

  // The candidate must know nobody and be known by everybody else.
  assign ok_next = ok && !((chk_idx != cand) && (cand_knows_chk || !chk_knows_cand));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      chk_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        chk_valid <= issue_go;
        chk_idx   <= iss;
        if (issue_go) begin
          iss <= iss + CW'(1);
        end
      end
      case (state)
        IDLE: begin
          if (start) begin
            n_r       <= n;
            iss       <= '0;
            chk_valid <= 1'b0;
            state     <= ELIM;
          end
        end
        ELIM: begin
          if (chk_valid) begin
            if ((chk_idx == '0) || cand_knows_chk) begin
              cand     <= chk_idx;
              cand_row <= rd_data;
            end
            if (chk_last) begin
              iss       <= '0;
              chk_valid <= 1'b0;
              ok        <= 1'b1;
              state     <= VERIFY;
            end
          end
        end
        VERIFY: begin
          if (chk_valid) begin
            ok <= ok_next;
            if (chk_last) begin
              done           <= 1'b1;
              res.found      <= ok_next;
              res.sink_index <= ok_next ? cand_ext[SINK_W-1:0] : '0;
              chk_valid      <= 1'b0;
              state          <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
